>>> src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> src/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies.
package bba_pkg;
  localparam int unsigned NumBlocks = 4096;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned NumWords  = NumBlocks / WordBits;
  localparam int unsigned WAddrW    = $clog2(NumWords);
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned BlkW      = 12;
  localparam int unsigned CntW      = 13;

  typedef enum logic [2:0] {
    OpAllocOne = 3'd0, OpAllocRun = 3'd1, OpFreeOne = 3'd2, OpFreeRun = 3'd3,
    OpTest = 3'd4, OpMarkUsed = 3'd5, OpMarkFree = 3'd6, OpNone = 3'd7
  } op_e;

  typedef struct packed {
    logic            ok;
    logic [BlkW-1:0] block_index_out;
    logic            is_used;
    logic [CntW-1:0] used_blocks;
  } result_t;
endpackage

>>> src/bitmap_block_allocator_core.sv
// Bitmap block allocator top level: sequencer around the bitmap word memory.
// Depends on bba_pkg, bba_word_ram and assert_macros.svh.
//
// One request is served at a time. After reset a clearing pass writes all
// ones into the 128 bitmap words before the first item is taken.
// Each word visited is read from memory and then, for allocation and range
// requests, worked on one bit at a time: a test only reads its word; free one
// and a mark or free run step through each block touched and write each word
// back; an allocation skips fully used words and scans partly free ones bit
// by bit, over at most active_blocks/32 words, followed on success by a
// marking pass over the run. The result is held in an output register so
// that the next item may be taken while it waits.
module bitmap_block_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,   // active_blocks
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i, // op[2:0], block_index[14:3], count[27:15]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o  // ok[0], block_index_out[12:1], is_used[13],
                                      // used_blocks[26:14]
);
  import bba_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [6:0] {
    StClear = 7'b0000001, StIdle = 7'b0000010, StRead = 7'b0000100,
    StWait  = 7'b0001000, StBits = 7'b0010000, StWrite = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]    active_q;
  logic [CntW-1:0]    used_q, used_d;
  op_e                op_q, op_d;
  logic [CntW:0]      pos_q, pos_d;      // current block index (may exceed range)
  logic [CntW-1:0]    left_q, left_d;    // blocks left to touch / run length
  logic [CntW-1:0]    len_q, len_d;
  logic [CntW-1:0]    run_q, run_d;
  logic [CntW-1:0]    first_q, first_d;
  logic [WordBits-1:0] word_q, word_d;
  logic               ok_q, ok_d, found_d, found_q;
  logic               res_valid_q;
  result_t            res_q, res_d;
  logic               res_load;
  logic [WAddrW:0]    clr_q;
  logic               we;
  logic [WAddrW-1:0]  waddr, raddr;
  logic [WordBits-1:0] wdata, rdata;
  logic [WAddrW:0]    words;
  logic [CntW-1:0]    eff;

  assign eff   = (active_q > CntW'(NumBlocks)) ? CntW'(NumBlocks) : active_q;
  assign words = eff[CntW-1:BitW];

  bba_word_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = {5'b0, res_q.used_blocks, res_q.is_used,
                            res_q.block_index_out, res_q.ok};

  logic is_alloc;
  assign is_alloc = (op_q == OpAllocOne) || (op_q == OpAllocRun);
  logic [BitW-1:0] bitpos;
  assign bitpos = pos_q[BitW-1:0];
  assign raddr  = pos_q[WAddrW+BitW-1:BitW];

  // sequencer
  always_comb begin
    state_d = state_q; used_d = used_q; op_d = op_q; pos_d = pos_q;
    left_d = left_q; len_d = len_q; run_d = run_q; first_d = first_q;
    word_d = word_q; ok_d = ok_q; found_d = found_q;
    res_d = res_q; res_load = 1'b0;
    we = 1'b0; waddr = raddr; wdata = word_q;
    case (state_q)
      StClear: begin
        we = 1'b1; waddr = clr_q[WAddrW-1:0]; wdata = '1;
        if (clr_q == (WAddrW+1)'(NumWords - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          op_d = op_e'(s_axis_tdata_i[2:0]);
          len_d = (op_d == OpAllocOne) ? CntW'(1) : s_axis_tdata_i[27:15];
          left_d = s_axis_tdata_i[27:15];
          run_d = '0; first_d = '0; found_d = 1'b0; ok_d = 1'b0;
          if (op_d == OpAllocOne || op_d == OpAllocRun) begin
            pos_d = '0;
            if (eff > used_q && len_d != '0 && words != '0) state_d = StRead;
            else state_d = StDone;
          end else if (op_d == OpNone) begin
            state_d = StDone;
          end else begin
            pos_d = {2'b0, s_axis_tdata_i[14:3]};
            ok_d = 1'b1;
            if (op_d == OpFreeOne) begin
              left_d = CntW'(1);
              used_d = (used_q != '0) ? used_q - 1'b1 : '0;
            end else if (op_d == OpFreeRun) begin
              used_d = (left_d < used_q) ? used_q - left_d : '0;
            end
            if (op_d != OpTest && left_d == '0) state_d = StDone;
            else state_d = StRead;
          end
        end
      end
      StRead: state_d = StWait;
      StWait: begin
        word_d = rdata;
        if (op_q == OpTest) begin
          found_d = rdata[bitpos];
          state_d = StDone;
        end else if (is_alloc && rdata == '1) begin
          run_d = '0;
          first_d = CntW'({pos_q[CntW-1:BitW], {BitW{1'b0}}} + CntW'(WordBits));
          pos_d = pos_q + (CntW+1)'(WordBits);
          if (pos_d[CntW:BitW] >= (CntW+1-BitW)'(words)) state_d = StDone;
          else state_d = StRead;
        end else begin
          state_d = StBits;
        end
      end
      StBits: begin
        if (is_alloc) begin
          if (word_q[bitpos]) begin
            run_d = '0; first_d = pos_q[CntW-1:0] + 1'b1;
          end else begin
            run_d = run_q + 1'b1;
            if (run_d == len_q) found_d = 1'b1;
          end
          pos_d = pos_q + 1'b1;
          if (found_d) begin
            pos_d = {1'b0, first_q}; left_d = len_q; ok_d = 1'b1;
            used_d = ((NumBlocks - used_q) > len_q) ? used_q + len_q : CntW'(NumBlocks);
            op_d = OpMarkUsed;       // reuse marking loop to set the run
            state_d = StRead;
          end else if (pos_d[BitW-1:0] == '0) begin
            if (pos_d[CntW:BitW] >= (CntW+1-BitW)'(words)) state_d = StDone;
            else state_d = StRead;
          end
        end else begin
          // free or mark one block per cycle, pausing at each word end for write-back and read
          if (op_q == OpFreeOne || op_q == OpFreeRun || op_q == OpMarkFree) begin
            if (op_q == OpMarkFree && word_q[bitpos] && used_q != '0) used_d = used_q - 1'b1;
            word_d[bitpos] = 1'b0;
          end else begin
            if (!word_q[bitpos] && !found_q && used_q != CntW'(NumBlocks))
              used_d = used_q + 1'b1;
            word_d[bitpos] = 1'b1;
          end
          pos_d = pos_q + 1'b1; left_d = left_q - 1'b1;
          if (left_d == '0 || pos_d[CntW:BitW] >= (CntW+1-BitW)'(NumWords)
              || pos_d[BitW-1:0] == '0) state_d = StWrite;
        end
      end
      StWrite: begin
        we = 1'b1; waddr = pos_q[WAddrW+BitW-1:BitW] - ((pos_q[BitW-1:0] == '0) ? 1'b1 : 1'b0);
        if (left_q == '0 || pos_q[CntW:BitW] >= (CntW+1-BitW)'(NumWords)) state_d = StDone;
        else state_d = StRead;
      end
      StDone: begin
        if (!res_valid_q || m_axis_tready_i) begin
          res_load = 1'b1;
          res_d.ok = ok_q;
          res_d.block_index_out = (is_alloc || (found_q && op_q == OpMarkUsed))
                                  ? first_q[BlkW-1:0] : '0;
          if (!ok_q) res_d.block_index_out = '0;
          res_d.is_used = (op_q == OpTest) ? (pos_q[CntW:BlkW] != '0 || found_q) : 1'b0;
          res_d.used_blocks = used_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; res_valid_q <= 1'b0;
      used_q <= CntW'(NumBlocks); active_q <= CntW'(NumBlocks);
    end else begin
      state_q <= state_d; used_q <= used_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (res_load) res_valid_q <= 1'b1;
      else if (m_axis_tready_i) res_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; pos_q <= pos_d; left_q <= left_d; len_q <= len_d;
    run_q <= run_d; first_q <= first_d; word_q <= word_d; ok_q <= ok_d;
    found_q <= found_d; res_q <= res_d;
  end

  `ASSERT_IMPLIES(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `ASSERT_IMPLIES(a_used_max, clk_i, rst_ni, 1'b1, used_q <= CntW'(NumBlocks))
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, res_load, state_q == StIdle && res_valid_q)
  `ASSERT_IMPLIES(a_no_take_busy, clk_i, rst_ni, state_q != StIdle, !s_axis_tready_o)
endmodule

>>> src/bba_word_ram.sv
// Bitmap word memory: one write port, one registered read port.
// Depends on bba_pkg.
module bba_word_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bba_pkg::WAddrW-1:0]  waddr_i,
  input  logic [bba_pkg::WordBits-1:0] wdata_i,
  input  logic [bba_pkg::WAddrW-1:0]  raddr_i,
  output logic [bba_pkg::WordBits-1:0] rdata_o
);
  import bba_pkg::*;
  logic [WordBits-1:0] mem [NumWords];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
